### design/hsv_to_rgbw_convert_top_assert.svh
// assertion macros for the hsv to rgbw converter checker
`ifndef HSV_TO_RGBW_CONVERT_TOP_ASSERT_SVH
`define HSV_TO_RGBW_CONVERT_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define HRC_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, off during reset
`define HRC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

// what must hold in the cycle after reset is seen
`define HRC_ASSERT_AFTER_RESET(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) (rst) |=> (prop)) \
      else $error(msg);

`endif

### design/hrc_pkg.sv
// shared types and constants of the hsv to rgbw converter
`default_nettype none

package hrc_pkg;

   localparam int FIELD_W          = 13;
   localparam int HUE_SECTOR_UNITS = 960;
   localparam int HUE_FULL_UNITS   = 5760;
   localparam int SEC_W            = 3;
   localparam int FRAC_W           = 10;

   // 960 = 15 << 6, divide by 15 through a reciprocal and one correction
   localparam int DIV_SHIFT   = 6;
   localparam int DIV_ODD     = 15;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 21;
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(((1 << RECIP_SHIFT) - 1) / DIV_ODD);

   localparam int NUM_STAGES    = 7;
   localparam int STAGE_SECTOR  = 0;
   localparam int STAGE_PRODUCT = 1;
   localparam int STAGE_RECIP   = 2;
   localparam int STAGE_CORRECT = 3;
   localparam int STAGE_SCALE   = 4;
   localparam int STAGE_SELECT  = 5;
   localparam int STAGE_DRIVE   = 6;

   typedef logic [FIELD_W-1:0] field_type;

   typedef enum logic [SEC_W-1:0] {
      SECTOR_R2Y = 3'd0,
      SECTOR_Y2G = 3'd1,
      SECTOR_G2C = 3'd2,
      SECTOR_C2B = 3'd3,
      SECTOR_B2M = 3'd4,
      SECTOR_M2R = 3'd5
   } sector_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

### design/hrc_channel_if.sv
// request and response channel interfaces of the hsv to rgbw converter
`default_nettype none

interface hrc_req_if;
   logic                valid;
   logic                ready;
   hrc_pkg::field_type  hue_sixteenths;
   hrc_pkg::field_type  saturation_level;
   hrc_pkg::field_type  brightness_level;

   modport source (output valid, hue_sixteenths, saturation_level, brightness_level,
                   input ready);
   modport sink (input valid, hue_sixteenths, saturation_level, brightness_level,
                 output ready);
endinterface

interface hrc_rsp_if;
   logic                valid;
   logic                ready;
   hrc_pkg::field_type  white_out;
   hrc_pkg::field_type  red_out;
   hrc_pkg::field_type  green_out;
   hrc_pkg::field_type  blue_out;

   modport source (output valid, white_out, red_out, green_out, blue_out,
                   input ready);
   modport sink (input valid, white_out, red_out, green_out, blue_out,
                 output ready);
endinterface

`default_nettype wire

### design/hsv_to_rgbw_convert_top.sv
// hsv to rgbw converter, seven-stage pipeline
// a request passes the sector, product, reciprocal, correct, scale, select and drive registers
// throughput: one request per cycle while the output is ready
// a stalled output holds; empty stages in between still take requests
// reset clears only the stage valid bits, datapath registers are not reset
`default_nettype none

module hsv_to_rgbw_convert_top #(
   parameter int LEVEL_FRAC_BITS = 12
) (
   input  wire logic     clock,
   input  wire logic     reset,
   hrc_req_if.sink       req_if,
   hrc_rsp_if.source     rsp_if
);
   import hrc_pkg::*;

   localparam int LW = LEVEL_FRAC_BITS + 1;

   pipe_ctrl_type     ctrl;

   logic [LW-1:0]     sat1, val1;
   sector_type        sec1;
   logic [FRAC_W-1:0] frac1, fracc1;

   logic [LW-1:0]     val4, plev4, kq4, kt4;
   sector_type        sec4;

   hrc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .out_ready (rsp_if.ready),
      .in_ready  (req_if.ready),
      .out_valid (rsp_if.valid),
      .ctrl      (ctrl)
   );

   hrc_sector #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_sector (
      .clock            (clock),
      .ctrl             (ctrl),
      .hue_sixteenths   (req_if.hue_sixteenths),
      .saturation_level (req_if.saturation_level),
      .brightness_level (req_if.brightness_level),
      .sat_ff           (sat1),
      .val_ff           (val1),
      .sec_ff           (sec1),
      .frac_ff          (frac1),
      .fracc_ff         (fracc1)
   );

   hrc_coef #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_coef (
      .clock   (clock),
      .ctrl    (ctrl),
      .sat     (sat1),
      .val     (val1),
      .sec     (sec1),
      .frac    (frac1),
      .fracc   (fracc1),
      .val_ff  (val4),
      .sec_ff  (sec4),
      .plev_ff (plev4),
      .kq_ff   (kq4),
      .kt_ff   (kt4)
   );

   hrc_mix #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_mix (
      .clock    (clock),
      .ctrl     (ctrl),
      .val      (val4),
      .sec      (sec4),
      .plev     (plev4),
      .kq       (kq4),
      .kt       (kt4),
      .white_ff (rsp_if.white_out),
      .red_ff   (rsp_if.red_out),
      .green_ff (rsp_if.green_out),
      .blue_ff  (rsp_if.blue_out)
   );

endmodule

`default_nettype wire

### design/hrc_pipe_ctrl.sv
// valid bits and per-stage load enables of the converter pipeline
`default_nettype none

module hrc_pipe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic                  out_ready,
   output logic                       in_ready,
   output logic                       out_valid,
   output hrc_pkg::pipe_ctrl_type     ctrl
);
   import hrc_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] src_vld;
   logic [NUM_STAGES:0]   rdy;

   always_comb begin
      rdy[NUM_STAGES] = out_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      src_vld   = {vld_ff[NUM_STAGES-2:0], in_valid};
      ctrl.load = src_vld & rdy[NUM_STAGES-1:0];
      for (int i = 0; i < NUM_STAGES; i++) begin
         vld_in[i] = rdy[i] ? src_vld[i] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NUM_STAGES-1];

endmodule

`default_nettype wire

### design/hrc_sector.sv
// input clamp and hue sector split
`default_nettype none

module hrc_sector #(
   parameter int LEVEL_FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire hrc_pkg::pipe_ctrl_type        ctrl,
   input  wire hrc_pkg::field_type            hue_sixteenths,
   input  wire hrc_pkg::field_type            saturation_level,
   input  wire hrc_pkg::field_type            brightness_level,
   output logic [LEVEL_FRAC_BITS:0]           sat_ff,
   output logic [LEVEL_FRAC_BITS:0]           val_ff,
   output hrc_pkg::sector_type                sec_ff,
   output logic [hrc_pkg::FRAC_W-1:0]         frac_ff,
   output logic [hrc_pkg::FRAC_W-1:0]         fracc_ff
);
   import hrc_pkg::*;

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam int CW = (LW > FIELD_W) ? LW : FIELD_W;
   localparam logic [CW-1:0] LVL_ONE = CW'(1) << LEVEL_FRAC_BITS;

   logic [CW-1:0]     sat_ext;
   logic [CW-1:0]     val_ext;
   logic [LW-1:0]     sat_in;
   logic [LW-1:0]     val_in;
   sector_type        sec_in;
   field_type         base;
   logic [FRAC_W-1:0] frac_in;
   logic [FRAC_W-1:0] fracc_in;

   always_comb begin
      sat_ext = CW'(saturation_level);
      val_ext = CW'(brightness_level);
      sat_in  = (sat_ext > LVL_ONE) ? LW'(LVL_ONE) : LW'(sat_ext);
      val_in  = (val_ext > LVL_ONE) ? LW'(LVL_ONE) : LW'(val_ext);

      base   = FIELD_W'(5 * HUE_SECTOR_UNITS);
      sec_in = SECTOR_M2R;
      if (hue_sixteenths >= FIELD_W'(HUE_FULL_UNITS)) begin
         base = hue_sixteenths;
      end else if (hue_sixteenths >= FIELD_W'(5 * HUE_SECTOR_UNITS)) begin
         base = FIELD_W'(5 * HUE_SECTOR_UNITS);
      end else if (hue_sixteenths >= FIELD_W'(4 * HUE_SECTOR_UNITS)) begin
         base   = FIELD_W'(4 * HUE_SECTOR_UNITS);
         sec_in = SECTOR_B2M;
      end else if (hue_sixteenths >= FIELD_W'(3 * HUE_SECTOR_UNITS)) begin
         base   = FIELD_W'(3 * HUE_SECTOR_UNITS);
         sec_in = SECTOR_C2B;
      end else if (hue_sixteenths >= FIELD_W'(2 * HUE_SECTOR_UNITS)) begin
         base   = FIELD_W'(2 * HUE_SECTOR_UNITS);
         sec_in = SECTOR_G2C;
      end else if (hue_sixteenths >= FIELD_W'(HUE_SECTOR_UNITS)) begin
         base   = FIELD_W'(HUE_SECTOR_UNITS);
         sec_in = SECTOR_Y2G;
      end else begin
         base   = '0;
         sec_in = SECTOR_R2Y;
      end
      frac_in  = FRAC_W'(hue_sixteenths - base);
      fracc_in = FRAC_W'(HUE_SECTOR_UNITS) - frac_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STAGE_SECTOR]) begin
         sat_ff   <= sat_in;
         val_ff   <= val_in;
         sec_ff   <= sec_in;
         frac_ff  <= frac_in;
         fracc_ff <= fracc_in;
      end
   end

endmodule

`default_nettype wire

### design/hrc_coef.sv
// sector blend coefficients: products, divide by 960, and the p level
`default_nettype none

module hrc_coef #(
   parameter int LEVEL_FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire hrc_pkg::pipe_ctrl_type        ctrl,
   input  wire logic [LEVEL_FRAC_BITS:0]      sat,
   input  wire logic [LEVEL_FRAC_BITS:0]      val,
   input  wire hrc_pkg::sector_type           sec,
   input  wire logic [hrc_pkg::FRAC_W-1:0]    frac,
   input  wire logic [hrc_pkg::FRAC_W-1:0]    fracc,
   output logic [LEVEL_FRAC_BITS:0]           val_ff,
   output hrc_pkg::sector_type                sec_ff,
   output logic [LEVEL_FRAC_BITS:0]           plev_ff,
   output logic [LEVEL_FRAC_BITS:0]           kq_ff,
   output logic [LEVEL_FRAC_BITS:0]           kt_ff
);
   import hrc_pkg::*;

   localparam int LW  = LEVEL_FRAC_BITS + 1;
   localparam int PAW = LW + FRAC_W;
   localparam int YW  = PAW - DIV_SHIFT;
   localparam int RW  = YW + RECIP_W;
   localparam int QW  = RW - RECIP_SHIFT;
   localparam logic [LW-1:0] LVL_ONE = LW'(1) << LEVEL_FRAC_BITS;

   // product stage
   logic [PAW-1:0]  pa_ff, pb_ff;
   logic [2*LW-1:0] pp_ff;
   logic [LW-1:0]   v2_ff;
   sector_type      sec2_ff;

   // reciprocal stage
   logic [YW-1:0]   ya_ff, yb_ff;
   logic [QW-1:0]   qa_ff, qb_ff;
   logic [LW-1:0]   p3_ff, v3_ff;
   sector_type      sec3_ff;

   logic [YW-1:0]   ya_in, yb_in;
   logic [RW-1:0]   ra_in, rb_in;
   logic [YW:0]     qa15, qb15;
   logic [YW-1:0]   rema, remb;
   logic [LW-1:0]   kq_in, kt_in;

   always_ff @(posedge clock) begin
      if (ctrl.load[STAGE_PRODUCT]) begin
         pa_ff   <= PAW'(sat) * PAW'(frac);
         pb_ff   <= PAW'(sat) * PAW'(fracc);
         pp_ff   <= (2*LW)'(val) * (2*LW)'(LVL_ONE - sat);
         v2_ff   <= val;
         sec2_ff <= sec;
      end
   end

   always_comb begin
      ya_in = pa_ff[PAW-1:DIV_SHIFT];
      yb_in = pb_ff[PAW-1:DIV_SHIFT];
      ra_in = RW'(ya_in) * RW'(RECIP_MUL);
      rb_in = RW'(yb_in) * RW'(RECIP_MUL);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STAGE_RECIP]) begin
         ya_ff   <= ya_in;
         yb_ff   <= yb_in;
         qa_ff   <= ra_in[RW-1:RECIP_SHIFT];
         qb_ff   <= rb_in[RW-1:RECIP_SHIFT];
         p3_ff   <= pp_ff[LEVEL_FRAC_BITS +: LW];
         v3_ff   <= v2_ff;
         sec3_ff <= sec2_ff;
      end
   end

   always_comb begin
      qa15  = {qa_ff, 4'b0000} - (YW+1)'(qa_ff);
      qb15  = {qb_ff, 4'b0000} - (YW+1)'(qb_ff);
      rema  = ya_ff - qa15[YW-1:0];
      remb  = yb_ff - qb15[YW-1:0];
      kq_in = LW'(qa_ff) + LW'(rema >= YW'(DIV_ODD));
      kt_in = LW'(qb_ff) + LW'(remb >= YW'(DIV_ODD));
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STAGE_CORRECT]) begin
         kq_ff   <= kq_in;
         kt_ff   <= kt_in;
         plev_ff <= p3_ff;
         val_ff  <= v3_ff;
         sec_ff  <= sec3_ff;
      end
   end

endmodule

`default_nettype wire

### design/hrc_mix.sv
// q and t levels, sector select, white extraction and output drive
`default_nettype none

module hrc_mix #(
   parameter int LEVEL_FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire hrc_pkg::pipe_ctrl_type        ctrl,
   input  wire logic [LEVEL_FRAC_BITS:0]      val,
   input  wire hrc_pkg::sector_type           sec,
   input  wire logic [LEVEL_FRAC_BITS:0]      plev,
   input  wire logic [LEVEL_FRAC_BITS:0]      kq,
   input  wire logic [LEVEL_FRAC_BITS:0]      kt,
   output hrc_pkg::field_type                 white_ff,
   output hrc_pkg::field_type                 red_ff,
   output hrc_pkg::field_type                 green_ff,
   output hrc_pkg::field_type                 blue_ff
);
   import hrc_pkg::*;

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam int CW = (LW > FIELD_W) ? LW : FIELD_W;
   localparam logic [LW-1:0] LVL_ONE  = LW'(1) << LEVEL_FRAC_BITS;
   localparam logic [LW-1:0] LVL_HALF = LW'(1) << (LEVEL_FRAC_BITS - 1);

   function automatic field_type drive(input logic [LW:0] x);
      logic [LW-1:0] sat;
      logic [CW-1:0] ext;
      sat = (x > {1'b0, LVL_ONE}) ? LVL_ONE : x[LW-1:0];
      ext = CW'(sat);
      return ext[FIELD_W-1:0];
   endfunction

   logic [2*LW-1:0] qp_in, tp_in;
   logic [LW-1:0]   q5_ff, t5_ff, p5_ff, v5_ff;
   sector_type      sec5_ff;

   logic [LW-1:0]   cr_in, cg_in, cb_in, mn, m_in;
   logic [LW-1:0]   cr_ff, cg_ff, cb_ff, m_ff;

   always_comb begin
      qp_in = (2*LW)'(val) * (2*LW)'(LVL_ONE - kq);
      tp_in = (2*LW)'(val) * (2*LW)'(LVL_ONE - kt);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STAGE_SCALE]) begin
         q5_ff   <= qp_in[LEVEL_FRAC_BITS +: LW];
         t5_ff   <= tp_in[LEVEL_FRAC_BITS +: LW];
         p5_ff   <= plev;
         v5_ff   <= val;
         sec5_ff <= sec;
      end
   end

   always_comb begin
      case (sec5_ff)
         SECTOR_R2Y: begin
            cr_in = v5_ff; cg_in = t5_ff; cb_in = p5_ff;
         end
         SECTOR_Y2G: begin
            cr_in = q5_ff; cg_in = v5_ff; cb_in = p5_ff;
         end
         SECTOR_G2C: begin
            cr_in = p5_ff; cg_in = v5_ff; cb_in = t5_ff;
         end
         SECTOR_C2B: begin
            cr_in = p5_ff; cg_in = q5_ff; cb_in = v5_ff;
         end
         SECTOR_B2M: begin
            cr_in = t5_ff; cg_in = p5_ff; cb_in = v5_ff;
         end
         default: begin
            cr_in = v5_ff; cg_in = p5_ff; cb_in = q5_ff;
         end
      endcase
      mn   = (cr_in < cg_in) ? cr_in : cg_in;
      mn   = (mn < cb_in) ? mn : cb_in;
      m_in = (mn > LVL_HALF) ? LVL_HALF : mn;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STAGE_SELECT]) begin
         cr_ff <= cr_in;
         cg_ff <= cg_in;
         cb_ff <= cb_in;
         m_ff  <= m_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STAGE_DRIVE]) begin
         white_ff <= drive({m_ff, 1'b0});
         red_ff   <= drive({cr_ff - m_ff, 1'b0});
         green_ff <= drive({cg_ff - m_ff, 1'b0});
         blue_ff  <= drive({cb_ff - m_ff, 1'b0});
      end
   end

endmodule

`default_nettype wire

### design/hrc_checker.sv
// port checker for the hsv to rgbw converter, bound to the top level
`default_nettype none
`include "hsv_to_rgbw_convert_top_assert.svh"

module hrc_checker #(
   parameter int LEVEL_FRAC_BITS = 12
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire hrc_pkg::field_type  rsp_white,
   input wire hrc_pkg::field_type  rsp_red,
   input wire hrc_pkg::field_type  rsp_green,
   input wire hrc_pkg::field_type  rsp_blue
);
   import hrc_pkg::*;

   localparam field_type LVL_LIM =
      (LEVEL_FRAC_BITS < FIELD_W) ? FIELD_W'(1 << LEVEL_FRAC_BITS) : '1;
   localparam field_type ONE_FIELD =
      FIELD_W'((1 << LEVEL_FRAC_BITS) % (1 << FIELD_W));

   `HRC_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_valid, "response valid after reset")

   `HRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_white) && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "stalled response changed")

   `HRC_ASSERT_SAME(a_level_range, clock, reset, rsp_valid, rsp_white <= LVL_LIM && rsp_red <= LVL_LIM && rsp_green <= LVL_LIM && rsp_blue <= LVL_LIM, "drive level above full scale")

   `HRC_ASSERT_SAME(a_white_split, clock, reset, rsp_valid, rsp_white == ONE_FIELD || rsp_red == '0 || rsp_green == '0 || rsp_blue == '0, "white not full yet no color channel dark")

endmodule

bind hsv_to_rgbw_convert_top hrc_checker #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_hrc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_white (rsp_if.white_out),
   .rsp_red   (rsp_if.red_out),
   .rsp_green (rsp_if.green_out),
   .rsp_blue  (rsp_if.blue_out)
);

`default_nettype wire
